// ===== sv/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants for the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int COUNT_WIDTH = 10;
	localparam int KEY_W       = 16;
	localparam int LIMIT_W     = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int EVENT_W     = 2;
	localparam int PHASE_W     = 3;
	// compare width wide enough for both counter and limit registers
	localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WATCHED_KEY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd2;

	localparam logic [KEY_W-1:0]   RST_WATCHED_KEY   = 16'd0;
	localparam logic [LIMIT_W-1:0] RST_HOLD_LIMIT    = 10'd300;
	localparam logic [LIMIT_W-1:0] RST_DOUBLE_WINDOW = 10'd30;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_UP       = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DOWN     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HELD     = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RELEASED = 3'd3;
	localparam logic [PHASE_W-1:0] PH_SINGLE   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DOUBLE   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_LONG     = 3'd6;
	localparam logic [PHASE_W-1:0] PH_UNUSED   = 3'd7;

	// event codes
	localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
	localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
	localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   watched_key;
		logic [LIMIT_W-1:0] hold_limit;
		logic [LIMIT_W-1:0] double_window;
	} cfg_t;

endpackage

// ===== sv/kcc_key_if.sv =====
// ----------------------------------------------------------------------------
// kcc_key_if
// Valid/ready channel carrying one key word per scan tick.
// ----------------------------------------------------------------------------
interface kcc_key_if;
	logic                     valid;
	logic                     ready;
	logic [kcc_pkg::KEY_W-1:0] key_word;

	modport source (output valid, output key_word, input ready);
	modport sink   (input valid, input key_word, output ready);
endinterface

// ===== sv/kcc_evt_if.sv =====
// ----------------------------------------------------------------------------
// kcc_evt_if
// Valid/ready channel carrying the event and phase after each tick.
// ----------------------------------------------------------------------------
interface kcc_evt_if;
	logic                        valid;
	logic                        ready;
	logic [kcc_pkg::EVENT_W-1:0] press_event;
	logic [kcc_pkg::PHASE_W-1:0] press_state;

	modport source (output valid, output press_event, output press_state, input ready);
	modport sink   (input valid, input press_event, input press_state, output ready);
endinterface

// ===== sv/kcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kcc_cfg_regs
// Configuration registers: watched key, hold limit and double-click window.
// ----------------------------------------------------------------------------
module kcc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [kcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output kcc_pkg::cfg_t                    cfg
);
	import kcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watched_key   <= RST_WATCHED_KEY;
			cfg_q.hold_limit    <= RST_HOLD_LIMIT;
			cfg_q.double_window <= RST_DOUBLE_WINDOW;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WATCHED_KEY:   cfg_q.watched_key   <= cfg_data[KEY_W-1:0];
				REG_HOLD_LIMIT:    cfg_q.hold_limit    <= cfg_data[LIMIT_W-1:0];
				REG_DOUBLE_WINDOW: cfg_q.double_window <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/kcc_fsm.sv =====
// ----------------------------------------------------------------------------
// kcc_fsm
// Press classifier state machine with saturating tick counter and sticky event.
// ----------------------------------------------------------------------------
module kcc_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [kcc_pkg::KEY_W-1:0]      key_word,
	input  kcc_pkg::cfg_t                  cfg,
	output logic [kcc_pkg::EVENT_W-1:0]    press_event,
	output logic [kcc_pkg::PHASE_W-1:0]    press_state
);
	import kcc_pkg::*;

	logic [PHASE_W-1:0]     phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
	logic [EVENT_W-1:0]     event_q, event_d;
	logic                   pressed;
	logic                   below_hold;
	logic                   below_window;

	assign pressed   = (key_word == cfg.watched_key);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	assign below_hold   = CMP_W'(count_inc) < CMP_W'(cfg.hold_limit);
	assign below_window = CMP_W'(count_inc) < CMP_W'(cfg.double_window);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		event_d = event_q;
		case (phase_q)
			PH_DOWN: begin
				phase_d = pressed ? PH_HELD : PH_UP;
			end
			PH_HELD: begin
				count_d = count_inc;
				if (below_hold) begin
					if (!pressed) begin
						count_d = '0;
						phase_d = PH_RELEASED;
					end
				end else begin
					count_d = '0;
					phase_d = PH_LONG;
				end
			end
			PH_RELEASED: begin
				count_d = count_inc;
				if (below_window) begin
					if (pressed) begin
						count_d = '0;
						phase_d = PH_DOUBLE;
					end
				end else begin
					count_d = '0;
					phase_d = PH_SINGLE;
				end
			end
			PH_SINGLE: begin
				event_d = EV_SINGLE;
				phase_d = PH_UP;
			end
			PH_DOUBLE: begin
				event_d = EV_DOUBLE;
				if (!pressed) phase_d = PH_UP;
			end
			PH_LONG: begin
				event_d = EV_LONG;
				if (!pressed) phase_d = PH_UP;
			end
			// up, and the unused code treated as up
			default: begin
				phase_d = pressed ? PH_DOWN : PH_UP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UP;
			count_q <= '0;
			event_q <= EV_NONE;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			event_q <= event_d;
		end
	end

	assign press_event = event_q;
	assign press_state = phase_q;

endmodule

// ===== sv/key_click_classifier_core.sv =====
// ----------------------------------------------------------------------------
// key_click_classifier_core
// Single, double and long press detector for one watched key code.
// An accepted key request passes the input register, then the state/result
// register, before its result is valid. Throughput: one request per cycle
// while output is not stalled. Async active-low reset returns the phase to up,
// clears count and event, and loads the config registers with their defaults.
// ----------------------------------------------------------------------------
module key_click_classifier_core (
	input  logic                             clk,
	input  logic                             arst_n,
	kcc_key_if.sink                          key,
	kcc_evt_if.source                        evt,
	input  logic                             cfg_wr_en,
	input  logic [kcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import kcc_pkg::*;

	cfg_t             cfg;
	logic             valid_s1;
	logic [KEY_W-1:0] key_word_s1;
	logic             out_valid_q;
	logic             step;

	// stage 1 moves into the state/result register when the output slot frees up
	assign step      = valid_s1 && (!out_valid_q || evt.ready);
	assign key.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.valid && key.ready) begin
			key_word_s1 <= key.key_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	kcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state registers double as the result register: they only change on step
	kcc_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.key_word    (key_word_s1),
		.cfg         (cfg),
		.press_event (evt.press_event),
		.press_state (evt.press_state)
	);

	assign evt.valid = out_valid_q;

endmodule

// ===== sv/kcc_checker.sv =====
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks for the key click classifier, bound to the top level.
// ----------------------------------------------------------------------------
module kcc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [kcc_pkg::EVENT_W-1:0]    press_event,
	input  logic [kcc_pkg::PHASE_W-1:0]    press_state
);
	import kcc_pkg::*;

	// unused phase code never shows up
	a_no_unused_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> press_state != PH_UNUSED)
		else $error("unused phase code on output");

	// stalled result holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(press_event) && $stable(press_state))
		else $error("stalled result changed");

	// once an event is reported it never goes back to none
	a_event_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_event != EV_NONE |=> press_event != EV_NONE)
		else $error("sticky event cleared");

	// a free output side never blocks the input side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output ready");

endmodule

bind key_click_classifier_core kcc_checker u_kcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (key.ready),
	.out_valid   (evt.valid),
	.out_ready   (evt.ready),
	.press_event (evt.press_event),
	.press_state (evt.press_state)
);
